/* sv/lbs_pkg.sv */
`timescale 1ns / 1ps
package lbs_pkg;

  localparam int WORD_W         = 32;
  localparam int WORDS_PER_BONE = 12;
  localparam int MAX_BONES      = 4;

  // item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SKIN  = 1'b1;

  localparam logic signed [9:0] WEIGHT_FULL = 10'sd255;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [9:0]        weight_t;

  // per-bone control travelling with each matrix read
  typedef struct packed {
    logic    valid;
    logic    first;
    logic    last;
    weight_t w;
  } bone_ctl_t;

endpackage

/* sv/lbs_if.sv */
`timescale 1ns / 1ps
interface lbs_vtx_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [9:0]        palette_address;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [5:0]        bone_a;
  logic [5:0]        bone_b;
  logic [5:0]        bone_c;
  logic [5:0]        bone_d;
  logic [7:0]        weight_a;
  logic [7:0]        weight_b;
  logic [7:0]        weight_c;
  modport source (output valid, operation, palette_address, pos_x, pos_y, pos_z,
                  bone_a, bone_b, bone_c, bone_d, weight_a, weight_b, weight_c,
                  input ready);
  modport sink (input valid, operation, palette_address, pos_x, pos_y, pos_z,
                bone_a, bone_b, bone_c, bone_d, weight_a, weight_b, weight_c,
                output ready);
endinterface

interface lbs_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               overflow;
  modport source (output valid, out_x, out_y, out_z, overflow, input ready);
  modport sink (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

interface lbs_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] influences;
  modport source (output valid, influences, input ready);
  modport sink (input valid, influences, output ready);
endinterface

/* sv/lbs_ram.sv */
`timescale 1ns / 1ps
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lbs_bone_map.sv */
`timescale 1ns / 1ps
module lbs_bone_map
  import lbs_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int TW        = 66 - FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bone_ctl_t            s1_ctl,
  input  logic                 s1_zero,
  input  word_t [2:0]          s1_pos,
  input  word_t [WORDS_PER_BONE-1:0] mat,
  output bone_ctl_t            t_ctl,
  output logic signed [TW-1:0] t_pt [3]
);

  bone_ctl_t          p_ctl;
  logic signed [63:0] prod [9];
  word_t              trans [3];

  // products: one multiplier per element of the 3x3 linear part
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r*3+c] <= s1_zero ? 64'sd0 :
                       64'($signed(mat[r*4+c])) * 64'($signed(s1_pos[c]));
      end
      trans[r] <= s1_zero ? word_t'(0) : $signed(mat[r*4+3]);
    end
    p_ctl.first <= s1_ctl.first;
    p_ctl.last  <= s1_ctl.last;
    p_ctl.w     <= s1_ctl.w;
    if (rst) begin
      p_ctl.valid <= 1'b0;
    end else begin
      p_ctl.valid <= s1_ctl.valid;
    end
  end

  // floor shift and row sum
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      t_pt[r] <= TW'(trans[r]) + TW'(prod[r*3] >>> FRAC_BITS)
               + TW'(prod[r*3+1] >>> FRAC_BITS) + TW'(prod[r*3+2] >>> FRAC_BITS);
    end
    t_ctl.first <= p_ctl.first;
    t_ctl.last  <= p_ctl.last;
    t_ctl.w     <= p_ctl.w;
    if (rst) begin
      t_ctl.valid <= 1'b0;
    end else begin
      t_ctl.valid <= p_ctl.valid;
    end
  end

endmodule

/* sv/lbs_blend.sv */
`timescale 1ns / 1ps
module lbs_blend
  import lbs_pkg::*;
#(
  parameter int TW = 50
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bone_ctl_t            t_ctl,
  input  logic signed [TW-1:0] t_pt [3],
  output logic                 o_valid,
  output word_t                o_pt [3],
  output logic                 o_ovf
);

  localparam int AW = TW + 12;               // accumulator
  localparam int HW = AW - 32;               // high part of accumulator
  localparam int YW = (HW > 33 ? HW : 33) + 1;
  localparam int ZW = YW - 15;
  localparam int UW = 18;
  localparam logic signed [AW-1:0] RECIP_HI = AW'(64'sd16843009);  // (2^32-1)/255
  localparam logic signed [AW-1:0] MUL_16   = AW'(64'sd257);       // (2^16-1)/255
  localparam logic [25:0]          RECIP_LO = 26'd16843010;
  localparam logic signed [AW-1:0] SAT_MAX  = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] SAT_MIN  = AW'(-64'sd2147483648);

  logic                         w_valid, w_first, w_last;
  logic signed [AW-1:0]         wt [3];
  logic signed [AW-1:0]         acc [3];
  logic signed [AW-1:0]         acc_sum [3];
  logic [4:0]                   v;
  logic signed [AW-1:0]         x [3];
  logic signed [YW-1:0]         y [3];
  logic signed [ZW-1:0]         z [3];
  logic signed [UW-1:0]         w3 [3];
  logic signed [AW-1:0]         ph [3];
  logic signed [AW-1:0]         ph2 [3];
  logic signed [AW-1:0]         ph3 [3];
  logic signed [AW-1:0]         ph4 [3];
  logic signed [AW-1:0]         qz [3];
  logic signed [AW-1:0]         q [3];
  logic [2:0]                   sat;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_sum[r] = (w_first ? AW'(0) : acc[r]) + wt[r];
      q[r]       = ph4[r] + qz[r];
      sat[r]     = (q[r] > SAT_MAX) || (q[r] < SAT_MIN);
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      wt[r] <= AW'(t_pt[r]) * AW'(t_ctl.w);
      if (w_valid) begin
        acc[r] <= acc_sum[r];
      end
      x[r]   <= acc_sum[r] + AW'(127);
      // x = 255*h*RECIP_HI + (h + l), h = x >>> 32
      y[r]   <= YW'(x[r] >>> 32) + YW'($signed({1'b0, x[r][31:0]}));
      ph[r]  <= AW'(x[r] >>> 32) * RECIP_HI;
      z[r]   <= ZW'(y[r] >>> 16) + ZW'($signed({1'b0, y[r][15:0]}));
      ph2[r] <= ph[r] + AW'(y[r] >>> 16) * MUL_16;
      w3[r]  <= UW'(z[r] >>> 16) + UW'($signed({1'b0, z[r][15:0]}));
      ph3[r] <= ph2[r] + AW'(z[r] >>> 16) * MUL_16;
      // bias by three divisors keeps the last step unsigned
      qz[r]  <= AW'(({25'd0, UW'(w3[r] + UW'(765))} * {17'd0, RECIP_LO}) >> 32) - AW'(3);
      ph4[r] <= ph3[r];
      o_pt[r] <= sat[r] ? (q[r][AW-1] ? word_t'(32'h8000_0000) : word_t'(32'h7fff_ffff))
                        : q[r][31:0];
    end
    w_first <= t_ctl.first;
    w_last  <= t_ctl.last;
    o_ovf   <= |sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      v       <= '0;
      o_valid <= 1'b0;
    end else begin
      w_valid <= t_ctl.valid;
      v       <= {v[3:0], w_valid && w_last};
      o_valid <= v[4];
    end
  end

endmodule

/* sv/linear_blend_skinning.sv */
`timescale 1ns / 1ps
// Results: a skin item's result is offered after its N bone reads pass the bone map and
// blend pipeline, N the bones blended (influences clamped to 1..4); writes give none.
// Throughput: the palette read port fetches one bone matrix (12 words, one per column RAM)
// a cycle, so an item holds the sequencer for its N reads; items follow back to back while
// the result queue has credit. Reset clears control and sets influences to 4; the palette
// is not cleared and reads undefined until written.
module linear_blend_skinning
  import lbs_pkg::*;
#(
  parameter int BONE_COUNT = 64,
  parameter int FRAC_BITS  = 16
) (
  input logic          clk,
  input logic          rst,
  lbs_vtx_if.sink      vtx,
  lbs_res_if.source    res,
  lbs_cfg_if.sink      cfg
);

  localparam int BW       = BONE_COUNT > 1 ? $clog2(BONE_COUNT) : 1;
  localparam int TW       = 66 - FRAC_BITS;
  localparam int QD       = 16;               // result queue depth
  localparam int QPW      = $clog2(QD);
  localparam logic [13:0] PAL_WORDS = 14'(BONE_COUNT * WORDS_PER_BONE);
  localparam logic [8:0]  BONE_LIM  = 9'(BONE_COUNT);

  // ---------------------------------------------------------------- config
  logic [2:0] influences;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      influences <= 3'd4;
    end else if (cfg.valid) begin
      influences <= cfg.influences;
    end
  end

  // ---------------------------------------------------------- input decode
  logic       accept, skin_acc, wr_acc;
  logic [7:0] wr_bone;
  logic [9:0] wr_base;
  logic [3:0] wr_elem;
  logic       wr_ok;

  assign accept   = vtx.valid && vtx.ready;
  assign skin_acc = accept && (vtx.operation == OP_SKIN);
  assign wr_acc   = accept && (vtx.operation == OP_WRITE);

  // address / 12: (addr >> 2) / 3 by reciprocal, exact over 10 bits
  assign wr_bone = 8'(({8'd0, vtx.palette_address[9:2]} * 16'd171) >> 9);
  assign wr_base = 10'({2'd0, wr_bone} * 10'd12);
  assign wr_elem = 4'(vtx.palette_address - wr_base);
  assign wr_ok   = {4'd0, vtx.palette_address} < PAL_WORDS;

  // ------------------------------------------------------- item sequencer
  // holds one skin item and issues one bone read a cycle
  logic          busy;
  logic [1:0]    cnt, nlast;
  logic [5:0]    bones [MAX_BONES];
  weight_t       wts [MAX_BONES];
  word_t [2:0]   pos;
  logic [1:0]    n_sel;
  weight_t       qa, qb, qc;
  logic          last_rd;
  logic [QPW:0]  pending;
  logic          credit;

  assign n_sel = (influences == 3'd0) ? 2'd0 :
                 (influences > 3'd4)  ? 2'd3 : 2'(influences - 3'd1);
  assign qa = weight_t'({2'b0, vtx.weight_a});
  assign qb = weight_t'({2'b0, vtx.weight_b});
  assign qc = weight_t'({2'b0, vtx.weight_c});

  assign last_rd   = busy && (cnt == nlast);
  assign credit    = pending < (QPW+1)'(QD);
  assign vtx.ready = credit && (!busy || last_rd);

  always_ff @(posedge clk) begin
    if (skin_acc) begin
      bones[0] <= vtx.bone_a;
      bones[1] <= vtx.bone_b;
      bones[2] <= vtx.bone_c;
      bones[3] <= vtx.bone_d;
      pos      <= {vtx.pos_z, vtx.pos_y, vtx.pos_x};
      nlast    <= n_sel;
      case (n_sel)
        2'd0: wts[0] <= WEIGHT_FULL;     // single bone: identity blend
        2'd1: begin
          // two bones: bone_b takes weight_a
          wts[0] <= WEIGHT_FULL - qa;
          wts[1] <= qa;
        end
        2'd2: begin
          wts[0] <= qa;
          wts[1] <= qb;
          wts[2] <= WEIGHT_FULL - qa - qb;
        end
        default: begin
          wts[0] <= qa;
          wts[1] <= qb;
          wts[2] <= qc;
          wts[3] <= WEIGHT_FULL - qa - qb - qc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (skin_acc) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (last_rd) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 2'd1;
    end
  end

  // ------------------------------------------------------- palette memory
  // one RAM per matrix element, row = bone
  logic [7:0]   rd_bone8;
  logic [BW-1:0] rd_addr;
  word_t [WORDS_PER_BONE-1:0] mat;

  assign rd_bone8 = {2'd0, bones[cnt]};
  assign rd_addr  = rd_bone8[BW-1:0];

  for (genvar k = 0; k < WORDS_PER_BONE; k++) begin : g_col
    lbs_ram #(
      .WIDTH(WORD_W),
      .DEPTH(BONE_COUNT)
    ) u_col (
      .clk  (clk),
      .we   (wr_acc && wr_ok && (wr_elem == 4'(k))),
      .waddr(wr_bone[BW-1:0]),
      .wdata(vtx.pos_x),
      .raddr(rd_addr),
      .rdata(mat[k])
    );
  end

  // control aligned with read data
  bone_ctl_t   s1_ctl;
  logic        s1_zero;
  word_t [2:0] s1_pos;

  always_ff @(posedge clk) begin
    s1_ctl.first <= (cnt == 2'd0);
    s1_ctl.last  <= last_rd;
    s1_ctl.w     <= wts[cnt];
    s1_zero      <= {1'b0, rd_bone8} >= BONE_LIM;   // bone off the palette maps to origin
    s1_pos       <= pos;
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else begin
      s1_ctl.valid <= busy;
    end
  end

  // ------------------------------------------------------------ datapath
  bone_ctl_t          t_ctl;
  logic signed [TW-1:0] t_pt [3];
  logic               b_valid;
  word_t              b_pt [3];
  logic               b_ovf;

  lbs_bone_map #(
    .FRAC_BITS(FRAC_BITS),
    .TW       (TW)
  ) u_map (
    .clk   (clk),
    .rst   (rst),
    .s1_ctl(s1_ctl),
    .s1_zero(s1_zero),
    .s1_pos(s1_pos),
    .mat   (mat),
    .t_ctl (t_ctl),
    .t_pt  (t_pt)
  );

  lbs_blend #(
    .TW(TW)
  ) u_blend (
    .clk    (clk),
    .rst    (rst),
    .t_ctl  (t_ctl),
    .t_pt   (t_pt),
    .o_valid(b_valid),
    .o_pt   (b_pt),
    .o_ovf  (b_ovf)
  );

  // --------------------------------------------------------- result queue
  // pending counts skin items accepted but not yet taken, so the queue
  // never overflows however long the sink stalls
  logic [96:0]  rq [QD];
  logic [QPW-1:0] wp, rp;
  logic [QPW:0]   fill;
  logic           pop;

  assign pop          = res.valid && res.ready;
  assign res.valid    = fill != '0;
  assign res.out_x    = $signed(rq[rp][31:0]);
  assign res.out_y    = $signed(rq[rp][63:32]);
  assign res.out_z    = $signed(rq[rp][95:64]);
  assign res.overflow = rq[rp][96];

  always_ff @(posedge clk) begin
    if (b_valid) begin
      rq[wp] <= {b_ovf, b_pt[2], b_pt[1], b_pt[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rp      <= '0;
      fill    <= '0;
      pending <= '0;
    end else begin
      if (b_valid) begin
        wp <= wp + QPW'(1);
      end
      if (pop) begin
        rp <= rp + QPW'(1);
      end
      fill    <= fill + (QPW+1)'(b_valid) - (QPW+1)'(pop);
      pending <= pending + (QPW+1)'(skin_acc) - (QPW+1)'(pop);
    end
  end

  // ----------------------------------------------------------- assertions
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (fill < (QPW+1)'(QD)) || pop)
    else $error("result queue overrun");

  a_fill_le_pending: assert property (@(posedge clk) disable iff (rst)
    fill <= pending)
    else $error("more results queued than items accepted");

  a_no_accept_mid_item: assert property (@(posedge clk) disable iff (rst)
    (busy && !last_rd) |-> !vtx.ready)
    else $error("item accepted while bone reads outstanding");

endmodule

/* test/tb_if.sv */
`timescale 1ns / 1ps
// The block's interfaces are reused as they stand; this file only adds two
// small bundle types, an input item and a result, used by the testbench.
package tb_skin_pkg;
  typedef struct {
    logic        op;
    logic [9:0]  addr;
    logic signed [31:0] px, py, pz;
    logic [5:0]  b [4];
    logic [7:0]  wa, wb, wc;
  } vtx_item_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               ovf;
  } skin_res_t;
endpackage

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lbs_pkg::*;
  import tb_skin_pkg::*;

  localparam int BONES     = 64;
  localparam int FRAC      = 16;
  localparam int PAL_WORDS = BONES * WORDS_PER_BONE;
  localparam int LIMIT     = 400000;

  logic clk = 0;
  logic rst = 1;

  lbs_vtx_if vtx ();
  lbs_res_if res ();
  lbs_cfg_if cfg ();

  linear_blend_skinning #(.BONE_COUNT(BONES), .FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst), .vtx(vtx.sink), .res(res.source), .cfg(cfg.sink)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: palette copy and blend count
  logic signed [31:0] pal [PAL_WORDS];
  logic [2:0]         blend_n;

  vtx_item_t  vtx_q [$];
  skin_res_t  skinned_q [$];
  int         fails = 0;
  bit         quiet = 0;   // stretch with no idling on either side
  longint     cycles = 0;

  function automatic longint floor_q(longint v);
    return v >>> FRAC;  // arithmetic shift is floor for signed values
  endfunction

  function automatic longint div255_half_up(longint n);
    longint q;
    n = n + 127;
    q = n / 255;
    if (n < 0 && (n % 255) != 0) q = q - 1;
    return q;
  endfunction

  // affine 3x4 map of one bone; out-of-palette bones map to the origin
  function automatic void bone_xform(input int bone, input longint p [3],
                                     output longint t [3]);
    int base;
    base = bone * WORDS_PER_BONE;
    for (int r = 0; r < 3; r++) begin
      if (bone >= BONES) begin
        t[r] = 0;
      end else begin
        t[r] = longint'(pal[base + r*4 + 3]);
        for (int c = 0; c < 3; c++)
          t[r] += floor_q(longint'(pal[base + r*4 + c]) * p[c]);
      end
    end
  endfunction

  // applies one accepted item to the predictor, queues any result
  function automatic void skin_predict(vtx_item_t it);
    longint p [3], t [4][3], w [4], v, sum;
    int n;
    skin_res_t e;
    if (it.op == OP_WRITE) begin
      if (it.addr < PAL_WORDS) pal[it.addr] = it.px;
      return;
    end
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    n = int'(blend_n);
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    w = '{0, 0, 0, 0};
    case (n)
      1: w[0] = 255;
      2: begin w[0] = 255 - it.wa; w[1] = it.wa; end
      3: begin w[0] = it.wa; w[1] = it.wb; w[2] = 255 - it.wa - it.wb; end
      default: begin
        w[0] = it.wa; w[1] = it.wb; w[2] = it.wc;
        w[3] = 255 - it.wa - it.wb - it.wc;
      end
    endcase
    for (int k = 0; k < n; k++) bone_xform(it.b[k], p, t[k]);
    e.ovf = 1'b0;
    for (int r = 0; r < 3; r++) begin
      if (n == 1) begin
        v = t[0][r];
      end else begin
        sum = 0;
        for (int k = 0; k < n; k++) sum += t[k][r] * w[k];
        v = div255_half_up(sum);
      end
      if (v > 64'sh7fffffff) begin v = 64'sh7fffffff; e.ovf = 1'b1; end
      if (v < -64'sh80000000) begin v = -64'sh80000000; e.ovf = 1'b1; end
      if (r == 0) e.x = v[31:0];
      else if (r == 1) e.y = v[31:0];
      else e.z = v[31:0];
    end
    skinned_q.push_back(e);
  endfunction

  // ---------------- driver ----------------
  initial begin
    vtx.valid = 0; vtx.operation = 0; vtx.palette_address = 0;
    vtx.pos_x = 0; vtx.pos_y = 0; vtx.pos_z = 0;
    vtx.bone_a = 0; vtx.bone_b = 0; vtx.bone_c = 0; vtx.bone_d = 0;
    vtx.weight_a = 0; vtx.weight_b = 0; vtx.weight_c = 0;
    res.ready = 0; cfg.valid = 0; cfg.influences = 4;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (vtx.valid && vtx.ready) begin
        skin_predict(vtx_q.pop_front());
      end
      // present the head of the queue unless idling this cycle
      if ((!vtx.valid || vtx.ready) && vtx_q.size() > 0 &&
          (vtx.valid && vtx.ready ? vtx_q.size() > 0 : 1)) begin
        if (quiet || $urandom_range(99) >= 10) begin
          vtx.valid           <= 1;
          vtx.operation       <= vtx_q[0].op;
          vtx.palette_address <= vtx_q[0].addr;
          vtx.pos_x <= vtx_q[0].px; vtx.pos_y <= vtx_q[0].py; vtx.pos_z <= vtx_q[0].pz;
          vtx.bone_a <= vtx_q[0].b[0]; vtx.bone_b <= vtx_q[0].b[1];
          vtx.bone_c <= vtx_q[0].b[2]; vtx.bone_d <= vtx_q[0].b[3];
          vtx.weight_a <= vtx_q[0].wa; vtx.weight_b <= vtx_q[0].wb;
          vtx.weight_c <= vtx_q[0].wc;
        end else begin
          vtx.valid <= 0;
        end
      end else if (vtx.valid && vtx.ready) begin
        vtx.valid <= 0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    skin_res_t e;
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (skinned_q.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h ovf=%b", $time,
                   res.out_x, res.out_y, res.out_z, res.overflow);
          fails++;
        end else begin
          e = skinned_q.pop_front();
          if (res.out_x !== e.x) begin
            $display("%0t: out_x expected %h actual %h", $time, e.x, res.out_x); fails++;
          end
          if (res.out_y !== e.y) begin
            $display("%0t: out_y expected %h actual %h", $time, e.y, res.out_y); fails++;
          end
          if (res.out_z !== e.z) begin
            $display("%0t: out_z expected %h actual %h", $time, e.z, res.out_z); fails++;
          end
          if (res.overflow !== e.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, e.ovf, res.overflow);
            fails++;
          end
        end
      end
      res.ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic vtx_item_t pal_write(int addr, logic signed [31:0] val);
    vtx_item_t it;
    it.op = OP_WRITE; it.addr = 10'(addr); it.px = val;
    it.py = $urandom; it.pz = $urandom;
    for (int k = 0; k < 4; k++) it.b[k] = 6'($urandom);
    it.wa = 8'($urandom); it.wb = 8'($urandom); it.wc = 8'($urandom);
    return it;
  endfunction

  // bones only from the written range so no unwritten word is read
  function automatic int draw_bone(int written);
    return $urandom_range(written - 1);
  endfunction

  function automatic vtx_item_t skin_item(int written);
    vtx_item_t it;
    it.op = OP_SKIN; it.addr = 10'($urandom);
    case ($urandom_range(3))
      0: begin it.px = $urandom; it.py = $urandom; it.pz = $urandom; end
      default: begin
        it.px = $signed($urandom_range(2**20)) - 2**19;
        it.py = $signed($urandom_range(2**20)) - 2**19;
        it.pz = $signed($urandom_range(2**20)) - 2**19;
      end
    endcase
    for (int k = 0; k < 4; k++) it.b[k] = 6'(draw_bone(written));
    it.wa = 8'($urandom); it.wb = 8'($urandom); it.wc = 8'($urandom);
    if ($urandom_range(1)) begin
      it.wa = 8'($urandom_range(85)); it.wb = 8'($urandom_range(85));
      it.wc = 8'($urandom_range(85));
    end
    return it;
  endfunction

  function automatic logic signed [31:0] mat_word();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'sh00010000;
      2: return $signed($urandom_range(2**17)) - 2**16;
      default: return $signed($urandom_range(2**21)) - 2**20;
    endcase
  endfunction

  task automatic wait_drain();
    while (vtx_q.size() > 0 || vtx.valid || skinned_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] v);
    cfg.valid <= 1; cfg.influences <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    blend_n = v;
    cfg.valid <= 0;
  endtask

  int written;
  logic [2:0] settings [7] = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5};

  initial begin
    vtx_item_t it;
    blend_n = 4;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: identity-ish bone 0, extreme bone 1, all of palette written
    // later in random phases
    for (int i = 0; i < 12; i++)
      vtx_q.push_back(pal_write(i, (i % 5 == 0) ? 32'sh00010000 : 32'sh0));
    for (int i = 12; i < 24; i++)
      vtx_q.push_back(pal_write(i, (i % 2) ? 32'sh7fffffff : -32'sh80000000));
    vtx_q.push_back(pal_write(1023, 32'sh12345678));  // beyond palette: dropped
    written = 2;
    it = skin_item(2); it.px = 32'sh7fffffff; it.py = -32'sh80000000; it.pz = 0;
    it.b = '{6'd0, 6'd1, 6'd0, 6'd1}; it.wa = 8'd255; it.wb = 8'd255; it.wc = 8'd255;
    vtx_q.push_back(it);
    it.b = '{6'd1, 6'd1, 6'd1, 6'd1}; it.wa = 8'd0; it.wb = 8'd0; it.wc = 8'd0;
    vtx_q.push_back(it);
    it.px = -1; it.py = 1; it.pz = 32'sh7fffffff; it.b = '{6'd0, 6'd0, 6'd0, 6'd0};
    vtx_q.push_back(it);
    wait_drain();

    for (int ph = 0; ph < 7; ph++) begin
      cfg_write(settings[ph]);
      quiet = (ph == 3);
      // fill more of the palette each phase; last phase covers all of it
      for (int i = 0; i < 10; i++) begin
        int a;
        a = $urandom_range(written * 12 - 1);
        vtx_q.push_back(pal_write(a, mat_word()));
      end
      while (written < (ph + 1) * 9 && written < BONES) begin
        for (int i = 0; i < 12; i++)
          vtx_q.push_back(pal_write(written * 12 + i, mat_word()));
        written++;
      end
      if (ph == 6) begin
        while (written < BONES) begin
          for (int i = 0; i < 12; i++)
            vtx_q.push_back(pal_write(written * 12 + i, mat_word()));
          written++;
        end
        for (int i = 0; i < 12; i++)
          vtx_q.push_back(pal_write(PAL_WORDS + $urandom_range(1023 - PAL_WORDS), $urandom));
      end
      for (int i = 0; i < 70; i++) vtx_q.push_back(skin_item(written));
      wait_drain();
    end
    quiet = 0;

    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
